[design/yrc_pkg.sv]
// Package of types, constants and helpers shared across the YUYV to RGB converter.
`timescale 1ns / 1ps

package yrc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ProdW = 18;
  localparam int unsigned RecipW = 19;
  localparam int unsigned MulW = ProdW + RecipW;
  localparam int unsigned SumW = 11;

  localparam int unsigned ChromaOffset = 128;
  localparam int unsigned CoefCrRed = 1402;
  localparam int unsigned CoefCbGreen = 344;
  localparam int unsigned CoefCrGreen = 714;
  localparam int unsigned CoefCbBlue = 1772;
  localparam int unsigned CoefScale = 1000;
  localparam int unsigned ChannelMax = 255;

  // floor(m / 1000) equals (m * RecipMul) >> RecipShift for every m below 2^ProdW.
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipMul = ((1 << RecipShift) + CoefScale - 1) / CoefScale;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [ProdW-1:0] prod_val_t;

  typedef struct packed {
    byte_t luma_first;
    byte_t luma_second;
    byte_t mag_blue;
    byte_t mag_red;
    logic  neg_blue;
    logic  neg_red;
  } prep_t;

  typedef struct packed {
    byte_t     luma_first;
    byte_t     luma_second;
    logic      neg_blue;
    logic      neg_red;
    prod_val_t prod_red;
    prod_val_t prod_green_blue;
    prod_val_t prod_green_red;
    prod_val_t prod_blue;
  } prod_t;

  typedef struct packed {
    byte_t luma_first;
    byte_t luma_second;
    logic  neg_blue;
    logic  neg_red;
    byte_t quot_red;
    byte_t quot_green_blue;
    byte_t quot_green_red;
    byte_t quot_blue;
  } quot_t;

  typedef struct packed {
    byte_t red_first;
    byte_t green_first;
    byte_t blue_first;
    byte_t red_second;
    byte_t green_second;
    byte_t blue_second;
  } rgb_t;

endpackage

[design/yrc_in_if.sv]
// Interface of the incoming YUYV macropixel channel.
`timescale 1ns / 1ps

interface yrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;

  modport source (
    output valid, luma_first, chroma_blue, luma_second, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma_first, chroma_blue, luma_second, chroma_red,
    output ready
  );
endinterface

[design/yrc_out_if.sv]
// Interface of the outgoing RGB888 pixel pair channel.
`timescale 1ns / 1ps

interface yrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;

  modport source (
    output valid, red_first, green_first, blue_first,
    output red_second, green_second, blue_second,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first,
    input  red_second, green_second, blue_second,
    output ready
  );
endinterface

[design/yrc_prep.sv]
// First stage: removes the chroma offset and splits each chroma value into sign and magnitude.
`timescale 1ns / 1ps

module yrc_prep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  yrc_pkg::byte_t luma_first_i,
  input  yrc_pkg::byte_t chroma_blue_i,
  input  yrc_pkg::byte_t luma_second_i,
  input  yrc_pkg::byte_t chroma_red_i,
  output logic          valid_o,
  input  logic          ready_i,
  output yrc_pkg::prep_t data_o
);
  import yrc_pkg::*;

  logic  valid_q;
  prep_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // A byte below the offset gives a negative value whose magnitude is offset minus byte.
  always_comb begin
    data_d.luma_first  = luma_first_i;
    data_d.luma_second = luma_second_i;
    data_d.neg_blue    = !chroma_blue_i[ByteW-1];
    data_d.neg_red     = !chroma_red_i[ByteW-1];
    data_d.mag_blue    = chroma_blue_i[ByteW-1] ? {1'b0, chroma_blue_i[ByteW-2:0]}
                                                : ByteW'(ChromaOffset) - chroma_blue_i;
    data_d.mag_red     = chroma_red_i[ByteW-1] ? {1'b0, chroma_red_i[ByteW-2:0]}
                                               : ByteW'(ChromaOffset) - chroma_red_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/yrc_product.sv]
// Second stage: multiplies the chroma magnitudes by the four colour coefficients.
`timescale 1ns / 1ps

module yrc_product (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  yrc_pkg::prep_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output yrc_pkg::prod_t data_o
);
  import yrc_pkg::*;

  logic      valid_q;
  prod_t     data_d, data_q;
  prod_val_t mag_blue_w, mag_red_w;

  assign ready_o    = !valid_q || ready_i;
  assign mag_blue_w = ProdW'(data_i.mag_blue);
  assign mag_red_w  = ProdW'(data_i.mag_red);

  always_comb begin
    data_d.luma_first      = data_i.luma_first;
    data_d.luma_second     = data_i.luma_second;
    data_d.neg_blue        = data_i.neg_blue;
    data_d.neg_red         = data_i.neg_red;
    data_d.prod_red        = mag_red_w * ProdW'(CoefCrRed);
    data_d.prod_green_blue = mag_blue_w * ProdW'(CoefCbGreen);
    data_d.prod_green_red  = mag_red_w * ProdW'(CoefCrGreen);
    data_d.prod_blue       = mag_blue_w * ProdW'(CoefCbBlue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/yrc_divide.sv]
// Third stage: divides each product magnitude by the coefficient scale through a reciprocal.
`timescale 1ns / 1ps

module yrc_divide (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  yrc_pkg::prod_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output yrc_pkg::quot_t data_o
);
  import yrc_pkg::*;

  logic  valid_q;
  quot_t data_d, data_q;

  function automatic byte_t scale_down(prod_val_t m);
    logic [MulW-1:0] full;
    full = MulW'(m) * MulW'(RecipMul);
    return ByteW'(full >> RecipShift);
  endfunction

  assign ready_o = !valid_q || ready_i;

  // Dividing the magnitude and keeping the sign apart truncates toward zero.
  always_comb begin
    data_d.luma_first      = data_i.luma_first;
    data_d.luma_second     = data_i.luma_second;
    data_d.neg_blue        = data_i.neg_blue;
    data_d.neg_red         = data_i.neg_red;
    data_d.quot_red        = scale_down(data_i.prod_red);
    data_d.quot_green_blue = scale_down(data_i.prod_green_blue);
    data_d.quot_green_red  = scale_down(data_i.prod_green_red);
    data_d.quot_blue       = scale_down(data_i.prod_blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/yrc_mix.sv]
// Fourth stage: adds the signed chroma terms to each luma and saturates every channel.
`timescale 1ns / 1ps

module yrc_mix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  yrc_pkg::quot_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output yrc_pkg::rgb_t  data_o
);
  import yrc_pkg::*;

  typedef logic signed [SumW-1:0] sum_t;

  logic valid_q;
  rgb_t data_d, data_q;
  sum_t term_red, term_green, term_blue;

  function automatic sum_t signed_term(logic neg, byte_t mag);
    sum_t val;
    val = sum_t'({{(SumW-ByteW){1'b0}}, mag});
    return neg ? -val : val;
  endfunction

  function automatic byte_t saturate(sum_t v);
    byte_t res;
    if (v < 0) begin
      res = '0;
    end else if (v > sum_t'(ChannelMax)) begin
      res = ByteW'(ChannelMax);
    end else begin
      res = v[ByteW-1:0];
    end
    return res;
  endfunction

  function automatic sum_t widen(byte_t luma);
    return sum_t'({{(SumW-ByteW){1'b0}}, luma});
  endfunction

  assign ready_o    = !valid_q || ready_i;
  assign term_red   = signed_term(data_i.neg_red, data_i.quot_red);
  assign term_blue  = signed_term(data_i.neg_blue, data_i.quot_blue);
  assign term_green = -signed_term(data_i.neg_blue, data_i.quot_green_blue)
                      - signed_term(data_i.neg_red, data_i.quot_green_red);

  always_comb begin
    data_d.red_first    = saturate(widen(data_i.luma_first) + term_red);
    data_d.green_first  = saturate(widen(data_i.luma_first) + term_green);
    data_d.blue_first   = saturate(widen(data_i.luma_first) + term_blue);
    data_d.red_second   = saturate(widen(data_i.luma_second) + term_red);
    data_d.green_second = saturate(widen(data_i.luma_second) + term_green);
    data_d.blue_second  = saturate(widen(data_i.luma_second) + term_blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/yuyv_to_rgb_convert_core.sv]
// Top level of the YUYV 4:2:2 to RGB888 converter.
`timescale 1ns / 1ps

// This block turns one YUYV macropixel word (two luma bytes with the Cb and Cr
// bytes they share) into one word of two RGB888 pixels, using BT.601-style
// integer coefficients with each chroma product divided by 1000, truncated
// toward zero, and each channel clamped to 0..255. It accepts one word per
// clock cycle while the output does not stall. The four register stages are
// offset removal, coefficient multiplication, reciprocal division and luma
// mixing with saturation. Every stage has its own valid bit and takes a new
// word whenever it is empty or its successor takes its word, so a stalled
// output fills the empty stages before input ready falls, and no word is lost
// or repeated. There is no state beyond the pipeline and reset only empties it.

module yuyv_to_rgb_convert_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  yrc_in_if.sink    pix_i,
  yrc_out_if.source rgb_o
);
  import yrc_pkg::*;

  // Handshake and payload between the stages.
  logic  prep_valid, prep_ready;
  logic  prod_valid, prod_ready;
  logic  quot_valid, quot_ready;
  prep_t prep_data;
  prod_t prod_data;
  quot_t quot_data;
  rgb_t  rgb_data;

  // Offset removal: each chroma byte becomes a sign and a magnitude.
  yrc_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (pix_i.valid),
    .ready_o       (pix_i.ready),
    .luma_first_i  (pix_i.luma_first),
    .chroma_blue_i (pix_i.chroma_blue),
    .luma_second_i (pix_i.luma_second),
    .chroma_red_i  (pix_i.chroma_red),
    .valid_o       (prep_valid),
    .ready_i       (prep_ready),
    .data_o        (prep_data)
  );

  // The four coefficient products, on magnitudes only.
  yrc_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  // Division by 1000 as a multiplication by a scaled reciprocal, which is
  // exact over the whole range of product magnitudes.
  yrc_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .valid_o (quot_valid),
    .ready_i (quot_ready),
    .data_o  (quot_data)
  );

  // The signs are put back, the terms added to each luma and the channels clamped.
  yrc_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (quot_valid),
    .ready_o (quot_ready),
    .data_i  (quot_data),
    .valid_o (rgb_o.valid),
    .ready_i (rgb_o.ready),
    .data_o  (rgb_data)
  );

  assign rgb_o.red_first    = rgb_data.red_first;
  assign rgb_o.green_first  = rgb_data.green_first;
  assign rgb_o.blue_first   = rgb_data.blue_first;
  assign rgb_o.red_second   = rgb_data.red_second;
  assign rgb_o.green_second = rgb_data.green_second;
  assign rgb_o.blue_second  = rgb_data.blue_second;

endmodule
